// ===== rtl/wss_pkg.sv =====
// Shared types and constants for the windowed sample statistics block.
package wss_pkg;

  // Item kinds on the input channel.
  localparam logic [2:0] KIND_SAMPLE  = 3'd0;
  localparam logic [2:0] KIND_TICK    = 3'd1;
  localparam logic [2:0] KIND_REFRESH = 3'd2;
  localparam logic [2:0] KIND_FORCE   = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

  // Reset value of the target period register, in microseconds.
  localparam logic [31:0] TARGET_PERIOD_RESET = 32'd1000000;

  // Depth of the report queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Number of quotient bits the shared divider produces.
  localparam int DIV_STEPS = 64;

  // Everything the back end needs to build one report.
  typedef struct packed {
    logic [63:0] count;
    logic [63:0] sum;
    logic [63:0] square_sum;
    logic [31:0] low;
    logic [31:0] high;
    logic [63:0] period;
    logic [31:0] target;
  } snapshot_t;

  // Request to the divider: (rem_init:dividend) / divisor, rem_init < divisor.
  typedef struct packed {
    logic        start;
    logic [63:0] rem_init;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  // Divider response; done pulses for one cycle with the quotient valid.
  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/wss_front.sv =====
// Front end: accepts items, keeps the running counters and takes report snapshots.
module wss_front #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [2:0]          kind,
  input  logic [31:0]         sample_value,
  input  logic [31:0]         elapsed_us,
  input  logic [31:0]         target_period,
  output logic                push,
  output wss_pkg::snapshot_t  snap
);

  localparam logic [31:0] SAMPLE_MASK = 32'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [63:0] time_now;
  logic [63:0] period_start;
  logic [63:0] sample_count;
  logic [63:0] sample_sum;
  logic [63:0] square_sum;
  logic [31:0] min_seen;
  logic [31:0] max_seen;

  logic                     is_sample, is_tick, is_refresh, is_force, is_clear;
  logic [31:0]              samp;
  logic [SAMPLE_BITS-1:0]   samp_n;
  logic [2*SAMPLE_BITS-1:0] samp_sq;
  logic [63:0]              count_next, sum_next, square_next, period;
  logic [31:0]              min_next, max_next, t_eff;
  logic                     over;

  // Decode the item kind; unused codes do nothing.
  always_comb begin
    is_sample  = 1'b0;
    is_tick    = 1'b0;
    is_refresh = 1'b0;
    is_force   = 1'b0;
    is_clear   = 1'b0;
    unique case (kind)
      wss_pkg::KIND_SAMPLE:  is_sample  = 1'b1;
      wss_pkg::KIND_TICK:    is_tick    = 1'b1;
      wss_pkg::KIND_REFRESH: is_refresh = 1'b1;
      wss_pkg::KIND_FORCE:   is_force   = 1'b1;
      wss_pkg::KIND_CLEAR:   is_clear   = 1'b1;
      default: ;
    endcase
  end

  // Only the low SAMPLE_BITS bits of a sample count.
  assign samp    = sample_value & SAMPLE_MASK;
  assign samp_n  = samp[SAMPLE_BITS-1:0];
  assign samp_sq = samp_n * samp_n;

  // Counter values including the current sample, if it is one.
  assign count_next  = is_sample ? sample_count + 64'd1 : sample_count;
  assign sum_next    = is_sample ? sample_sum + 64'(samp) : sample_sum;
  assign square_next = is_sample ? square_sum + 64'(samp_sq) : square_sum;
  assign min_next    = (is_sample && samp < min_seen) ? samp : min_seen;
  assign max_next    = (is_sample && samp > max_seen) ? samp : max_seen;

  // Period end test; a zero target acts as one.
  assign t_eff  = (target_period == 32'd0) ? 32'd1 : target_period;
  assign period = time_now - period_start;
  assign over   = period >= {32'd0, t_eff};

  assign push = accept && (is_force || ((is_sample || is_refresh) && over));

  // Snapshot of the period that ends with this item.
  always_comb begin
    snap.count      = count_next;
    snap.sum        = sum_next;
    snap.square_sum = square_next;
    snap.low        = (count_next != 64'd0) ? min_next : 32'd0;
    snap.high       = max_next;
    snap.period     = period;
    snap.target     = t_eff;
  end

  // Running state.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now     <= '0;
      period_start <= '0;
      sample_count <= '0;
      sample_sum   <= '0;
      square_sum   <= '0;
      min_seen     <= '1;
      max_seen     <= '0;
    end else if (accept) begin
      if (is_tick) begin
        time_now <= time_now + 64'(elapsed_us);
      end
      if (push || is_clear) begin
        period_start <= time_now;
        sample_count <= '0;
        sample_sum   <= '0;
        square_sum   <= '0;
        min_seen     <= '1;
        max_seen     <= '0;
      end else if (is_sample) begin
        sample_count <= count_next;
        sample_sum   <= sum_next;
        square_sum   <= square_next;
        min_seen     <= min_next;
        max_seen     <= max_next;
      end
    end
  end

endmodule

// ===== rtl/wss_queue.sv =====
// Short queue of report snapshots between the front and back ends.
module wss_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wss_pkg::snapshot_t  push_data,
  input  logic                pop,
  output wss_pkg::snapshot_t  head,
  output logic                not_empty,
  output logic                full
);

  localparam int PTR_W = (wss_pkg::QUEUE_DEPTH > 1) ? $clog2(wss_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(wss_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(wss_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(wss_pkg::QUEUE_DEPTH);

  wss_pkg::snapshot_t entries [wss_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign head      = entries[rd_ptr];
  assign not_empty = fill != '0;
  assign full      = fill == DEPTH_CNT;

  // Storage writes; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/wss_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module wss_div (
  input  logic               clk,
  input  logic               rst,
  input  wss_pkg::div_req_t  req,
  output wss_pkg::div_rsp_t  rsp
);

  localparam int CNT_W = $clog2(wss_pkg::DIV_STEPS);

  logic [63:0]      rem;
  logic [63:0]      quo;
  logic [63:0]      dvs;
  logic [CNT_W-1:0] steps_left;
  logic             busy;
  logic             done;
  logic [64:0]      shifted;
  logic             fits;

  // One step: shift in the next dividend bit and try to subtract.
  assign shifted = {rem, quo[63]};
  assign fits    = shifted >= {1'b0, dvs};

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy       <= 1'b1;
        steps_left <= CNT_W'(wss_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        steps_left <= steps_left - CNT_W'(1);
        if (steps_left == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? 64'(shifted - {1'b0, dvs}) : shifted[63:0];
      quo <= {quo[62:0], fits};
    end
  end

endmodule

// ===== rtl/wss_back.sv =====
// Back end: turns one snapshot into a report using a sliced multiplier and the divider.
module wss_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_not_empty,
  input  wss_pkg::snapshot_t  q_head,
  output logic                q_pop,
  output wss_pkg::div_req_t   div_req,
  input  wss_pkg::div_rsp_t   div_rsp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         scaled_count,
  output logic [31:0]         mean_value,
  output logic [63:0]         variance_value,
  output logic [31:0]         low_water,
  output logic [31:0]         high_water,
  output logic [63:0]         actual_period
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_SCALE,
    S_MEAN,
    S_MSQ,
    S_SQR,
    S_VAR,
    S_OUT
  } state_t;

  state_t             state;
  wss_pkg::snapshot_t snap;
  logic [127:0]       acc;
  logic [63:0]        pp;
  logic [1:0]         pp_shift;
  logic               pp_live;
  logic [2:0]         prod_step;
  logic [63:0]        scaled;
  logic [31:0]        mean;
  logic [63:0]        msq;
  logic [63:0]        sq;
  logic [63:0]        var_q;
  logic [31:0]        a_half;
  logic [31:0]        b_half;
  logic               no_samples;

  assign q_pop      = (state == S_IDLE) && q_not_empty;
  assign no_samples = snap.count == 64'd0;

  // Slice selection for count times period, one 32x32 product per step.
  assign a_half = prod_step[0] ? snap.count[63:32] : snap.count[31:0];
  assign b_half = prod_step[1] ? snap.period[63:32] : snap.period[31:0];

  // Sequencer with its datapath and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
      pp_live       <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            snap      <= q_head;
            acc       <= '0;
            prod_step <= '0;
            pp_live   <= 1'b0;
            state     <= S_PROD;
          end
        end
        S_PROD: begin
          // Steps 0-3 multiply, steps 1-4 accumulate, step 5 checks saturation.
          if (prod_step < 3'd4) begin
            pp       <= a_half * b_half;
            pp_shift <= {1'b0, prod_step[0]} + {1'b0, prod_step[1]};
            pp_live  <= 1'b1;
          end else begin
            pp_live <= 1'b0;
          end
          if (pp_live) begin
            acc <= acc + (128'(pp) << {pp_shift, 5'd0});
          end
          prod_step <= prod_step + 3'd1;
          if (prod_step == 3'd5) begin
            if (acc[127:64] >= {32'd0, snap.target}) begin
              scaled <= '1;
              if (no_samples) begin
                mean  <= '0;
                var_q <= '0;
                state <= S_OUT;
              end else begin
                div_req.start    <= 1'b1;
                div_req.rem_init <= '0;
                div_req.dividend <= snap.sum;
                div_req.divisor  <= snap.count;
                state            <= S_MEAN;
              end
            end else begin
              div_req.start    <= 1'b1;
              div_req.rem_init <= acc[127:64];
              div_req.dividend <= acc[63:0];
              div_req.divisor  <= {32'd0, snap.target};
              state            <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          if (div_rsp.done) begin
            scaled <= div_rsp.quotient;
            if (no_samples) begin
              mean  <= '0;
              var_q <= '0;
              state <= S_OUT;
            end else begin
              div_req.start    <= 1'b1;
              div_req.rem_init <= '0;
              div_req.dividend <= snap.sum;
              div_req.divisor  <= snap.count;
              state            <= S_MEAN;
            end
          end
        end
        S_MEAN: begin
          if (div_rsp.done) begin
            mean             <= div_rsp.quotient[31:0];
            div_req.start    <= 1'b1;
            div_req.rem_init <= '0;
            div_req.dividend <= snap.square_sum;
            div_req.divisor  <= snap.count;
            state            <= S_MSQ;
          end
        end
        S_MSQ: begin
          if (div_rsp.done) begin
            msq   <= div_rsp.quotient;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          sq    <= mean * mean;
          state <= S_VAR;
        end
        S_VAR: begin
          // A wrapped square sum can make the difference negative; clamp to zero.
          var_q <= (msq >= sq) ? msq - sq : '0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            scaled_count   <= scaled;
            mean_value     <= mean;
            variance_value <= var_q;
            low_water      <= snap.low;
            high_water     <= snap.high;
            actual_period  <= snap.period;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/windowed_sample_statistics.sv =====
// Top level of the windowed sample statistics block.
// The front end takes one item per cycle unless the queue is full: samples, time
// advances, refresh checks and clears all complete in the cycle they are accepted.
// An item that ends a period hands a snapshot of the counters to a two-entry queue;
// the back end takes it from the queue, forms the sliced count-by-period product,
// makes up to three passes through the shared one-bit-per-cycle divider, computes
// the variance and loads the output register; a period with no samples needs only
// the count-scaling pass. The input stalls only while the queue is full, so reports
// closer together than the back end can finish them throttle the input to the
// divider's pace. The user must write target_period through the configuration channel
// only while the block is idle, which the block does not enforce; cfg_ready is always high.
module windowed_sample_statistics #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [31:0] sample_value,
  input  logic [31:0] elapsed_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] scaled_count,
  output logic [31:0] mean_value,
  output logic [63:0] variance_value,
  output logic [31:0] low_water,
  output logic [31:0] high_water,
  output logic [63:0] actual_period
);

  logic [31:0]        target_period;
  logic               accept;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_not_empty;
  wss_pkg::snapshot_t push_snap;
  wss_pkg::snapshot_t head_snap;
  wss_pkg::div_req_t  div_req;
  wss_pkg::div_rsp_t  div_rsp;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_period <= wss_pkg::TARGET_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      target_period <= cfg_data;
    end
  end

  // Input transaction handshake.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  wss_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .kind         (kind),
    .sample_value (sample_value),
    .elapsed_us   (elapsed_us),
    .target_period(target_period),
    .push         (push),
    .snap         (push_snap)
  );

  wss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_snap),
    .pop      (pop),
    .head     (head_snap),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  wss_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  wss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_head        (head_snap),
    .q_pop         (pop),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scaled_count  (scaled_count),
    .mean_value    (mean_value),
    .variance_value(variance_value),
    .low_water     (low_water),
    .high_water    (high_water),
    .actual_period (actual_period)
  );

endmodule

// ===== tb/windowed_sample_statistics_tb.sv =====
// Self-checking testbench for the windowed sample statistics block.
`timescale 1ns / 100ps

module windowed_sample_statistics_tb;

  localparam int SAMPLE_BITS = 32;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  // Settling margin for the longest report path plus receiver stalls.
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEMS_PER_PHASE = 230;

  // One report as seen on the output channel.
  typedef struct {
    logic [63:0] scaled;
    logic [31:0] mean;
    logic [63:0] variance;
    logic [31:0] low;
    logic [31:0] high;
    logic [63:0] period;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = wss_pkg::KIND_SAMPLE;
  logic [31:0] sample_value = '0;
  logic [31:0] elapsed_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] scaled_count;
  logic [31:0] mean_value;
  logic [63:0] variance_value;
  logic [31:0] low_water;
  logic [31:0] high_water;
  logic [63:0] actual_period;

  // Shadow copy of the block's statistics state.
  logic [31:0] target_reg;
  logic [63:0] clock_us;
  logic [63:0] window_start;
  logic [63:0] sample_total;
  logic [63:0] value_sum;
  logic [63:0] square_total;
  logic [31:0] lowest;
  logic [31:0] highest;

  report_t pending_reports[$];
  int      error_count = 0;
  int      reports_checked = 0;
  int      items_sent = 0;
  int      targets_used = 0;
  int      cycle_count = 0;
  int      burst_left = 0;
  bit      sender_gaps = 1'b1;
  int      stall_run = 0;

  windowed_sample_statistics #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .sample_value(sample_value),
    .elapsed_us(elapsed_us),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .scaled_count(scaled_count),
    .mean_value(mean_value),
    .variance_value(variance_value),
    .low_water(low_water),
    .high_water(high_water),
    .actual_period(actual_period)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Count scaled to the target period, floored and saturated at 64 bits.
  function automatic logic [63:0] scaled_count_of(logic [63:0] n, logic [63:0] p,
                                                  logic [63:0] t);
    logic [127:0] product;
    logic [127:0] quotient;
    product = {64'd0, n} * {64'd0, p};
    if (product[127:64] >= t) return '1;
    quotient = product / {64'd0, t};
    return quotient[63:0];
  endfunction

  function automatic void clear_window();
    sample_total = '0;
    value_sum = '0;
    square_total = '0;
    lowest = '1;
    highest = '0;
  endfunction

  // Close the period if it has run out or is forced, queueing the report it yields.
  function automatic void close_period(bit forced);
    logic [63:0] span;
    logic [63:0] eff_target;
    logic [63:0] avg;
    logic [63:0] avg_square;
    logic [63:0] square_avg;
    report_t rep;
    span = clock_us - window_start;
    eff_target = (target_reg == 0) ? 64'd1 : {32'd0, target_reg};
    if (!forced && span < eff_target) return;
    avg = '0;
    rep.variance = '0;
    if (sample_total != 0) begin
      avg = value_sum / sample_total;
      square_avg = square_total / sample_total;
      avg_square = {32'd0, avg[31:0]} * {32'd0, avg[31:0]};
      rep.variance = (square_avg >= avg_square) ? square_avg - avg_square : 64'd0;
    end
    rep.scaled = scaled_count_of(sample_total, span, eff_target);
    rep.mean = avg[31:0];
    rep.low = (sample_total != 0) ? lowest : 32'd0;
    rep.high = highest;
    rep.period = span;
    pending_reports = {pending_reports, rep};
    window_start = clock_us;
    clear_window();
  endfunction

  // Apply one accepted transaction to the shadow state.
  function automatic void predict_item(logic [2:0] k, logic [31:0] raw, logic [31:0] dt);
    logic [63:0] s;
    s = {32'd0, raw} & ((64'd1 << SAMPLE_BITS) - 64'd1);
    case (k)
      wss_pkg::KIND_SAMPLE: begin
        sample_total = sample_total + 64'd1;
        value_sum = value_sum + s;
        square_total = square_total + s * s;
        if (s[31:0] < lowest) lowest = s[31:0];
        if (s[31:0] > highest) highest = s[31:0];
        close_period(1'b0);
      end
      wss_pkg::KIND_TICK: clock_us = clock_us + {32'd0, dt};
      wss_pkg::KIND_REFRESH: close_period(1'b0);
      wss_pkg::KIND_FORCE: close_period(1'b1);
      wss_pkg::KIND_CLEAR: begin
        window_start = clock_us;
        clear_window();
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected 0x%016h, got 0x%016h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Compare delivered reports, then track accepted config and input transactions.
  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      target_reg = wss_pkg::TARGET_PERIOD_RESET;
      clock_us = '0;
      window_start = '0;
      clear_window();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: report with nothing expected, period 0x%016h", $time, actual_period);
          error_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("scaled_count", want.scaled, scaled_count);
          check_field("mean_value", {32'd0, want.mean}, {32'd0, mean_value});
          check_field("variance_value", want.variance, variance_value);
          check_field("low_water", {32'd0, want.low}, {32'd0, low_water});
          check_field("high_water", {32'd0, want.high}, {32'd0, high_water});
          check_field("actual_period", want.period, actual_period);
          reports_checked++;
        end
      end
      if (cfg_valid && cfg_ready === 1'b1) target_reg = cfg_data;
      if (in_valid && in_stall === 1'b0) predict_item(kind, sample_value, elapsed_us);
    end
  end

  // Receiver stalls in runs; it rotates through a calm phase, a phase of short runs and a phase of long runs.
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if ((cycle_count / 3000) % 3 == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_run <= $urandom_range(0, ((cycle_count / 3000) % 3 == 1) ? 3 : 40);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d reports outstanding", $time, pending_reports.size());
      $display("windowed_sample_statistics_tb NOT OK");
      $finish;
    end
  end

  // Send one input transaction, with bursts and gaps when enabled.
  task automatic send_item(logic [2:0] k, logic [31:0] s, logic [31:0] dt);
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    kind <= k;
    sample_value <= s;
    elapsed_us <= dt;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  // Wait until every expected report is in and the back end has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    targets_used++;
  endtask

  // Reset target: empty forced report, extreme samples, period boundary, ignored kinds.
  task automatic test_reset_period();
    send_item(wss_pkg::KIND_FORCE, '0, '0);
    send_item(wss_pkg::KIND_SAMPLE, 32'h0000_0000, '0);
    send_item(wss_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, '0);
    send_item(wss_pkg::KIND_TICK, '0, wss_pkg::TARGET_PERIOD_RESET - 32'd1);
    send_item(wss_pkg::KIND_REFRESH, '0, '0);
    send_item(wss_pkg::KIND_TICK, '0, 32'd1);
    send_item(KIND_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_UNUSED_MID, 32'h5555_5555, 32'd10);
    send_item(KIND_UNUSED_HI, 32'hAAAA_AAAA, 32'd10);
    send_item(wss_pkg::KIND_REFRESH, '0, '0);
    send_item(wss_pkg::KIND_SAMPLE, 32'd9, '0);
    send_item(wss_pkg::KIND_CLEAR, '0, '0);
    send_item(wss_pkg::KIND_FORCE, '0, '0);
    settle();
  endtask

  // Two full-scale samples wrap the square sum, so the variance clamps to zero.
  task automatic test_square_wrap();
    send_item(wss_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, '0);
    send_item(wss_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, '0);
    send_item(wss_pkg::KIND_FORCE, '0, '0);
    settle();
  endtask

  // Zero target acts as one; the largest target is reached by a full-scale tick.
  task automatic test_target_bounds();
    write_target(32'd0);
    send_item(wss_pkg::KIND_SAMPLE, 32'd3, '0);
    send_item(wss_pkg::KIND_TICK, '0, 32'd1);
    send_item(wss_pkg::KIND_SAMPLE, 32'd5, '0);
    send_item(wss_pkg::KIND_TICK, '0, 32'd2);
    send_item(wss_pkg::KIND_REFRESH, '0, '0);
    settle();
    write_target(32'hFFFF_FFFF);
    send_item(wss_pkg::KIND_TICK, '0, 32'hFFFF_FFFF);
    send_item(wss_pkg::KIND_SAMPLE, 32'h0001_2345, '0);
    settle();
  endtask

  // Random traffic for one target setting; ignored kinds do not count toward the total.
  task automatic random_phase(logic [31:0] t, int items);
    int          done_items;
    int          roll;
    logic [63:0] span;
    logic [31:0] s;
    logic [31:0] dt;
    done_items = 0;
    span = (t == 0) ? 64'd2 : 64'd2 * t;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    write_target(t);
    while (done_items < items) begin
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: s = $urandom;
        4, 5: s = $urandom_range(0, 255);
        6: s = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
        7: s = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        default: s = $urandom_range(0, 65535);
      endcase
      dt = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, span[31:0]);
      if (roll < 58) send_item(wss_pkg::KIND_SAMPLE, s, $urandom);
      else if (roll < 72) send_item(wss_pkg::KIND_TICK, $urandom, dt);
      else if (roll < 82) send_item(wss_pkg::KIND_REFRESH, $urandom, $urandom);
      else if (roll < 88) send_item(wss_pkg::KIND_FORCE, $urandom, $urandom);
      else if (roll < 93) send_item(wss_pkg::KIND_CLEAR, $urandom, $urandom);
      else send_item(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), s, dt);
      if (roll < 93) done_items++;
    end
    settle();
  endtask

  task automatic test_random_traffic();
    logic [31:0] phase_targets[7];
    phase_targets = '{32'd1, 32'd37, 32'd1000, 32'd0, wss_pkg::TARGET_PERIOD_RESET,
                      32'hFFFF_FFFF, 32'd0};
    phase_targets[6] = $urandom_range(1, 100000);
    foreach (phase_targets[i]) begin
      sender_gaps = (i % 3 != 1);
      random_phase(phase_targets[i], ITEMS_PER_PHASE);
    end
  endtask

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_period();
    test_square_wrap();
    test_target_bounds();
    test_random_traffic();
    $display("Sent %0d transactions and checked %0d reports across %0d target settings.",
             items_sent, reports_checked, targets_used);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("windowed_sample_statistics_tb OK");
    end else begin
      $display("%0d mismatches, %0d reports never delivered",
               error_count, pending_reports.size());
      $display("windowed_sample_statistics_tb NOT OK");
    end
    $finish;
  end

endmodule
